>>> sv/sipf_pkg.sv
// shared constants, types and match function for the source address filter table
package sipf_pkg;

    localparam int RULE_SLOTS = 16;
    localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(RULE_SLOTS + 1);

    // operation codes
    localparam logic [1:0] FUNC_CHECK = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // protocol classes
    localparam logic [1:0] CLASS_ALL  = 2'd0;
    localparam logic [1:0] CLASS_TCP  = 2'd1;
    localparam logic [1:0] CLASS_ICMP = 2'd2;
    localparam logic [1:0] CLASS_UDP  = 2'd3;

    // ip protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef struct packed {
        logic [31:0] src;
        logic        forbid;
        logic [1:0]  cls;
    } rule_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic load_out;
    } sipf_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } sipf_stat_t;

    function automatic logic rule_hits(rule_t r, logic [31:0] src, logic [7:0] proto);
        logic covers;
        case (r.cls)
            CLASS_ALL:  covers = 1'b1;
            CLASS_TCP:  covers = (proto == PROTO_TCP);
            CLASS_ICMP: covers = (proto == PROTO_ICMP);
            default:    covers = (proto == PROTO_UDP);
        endcase
        return (r.src == src) && r.forbid && covers;
    endfunction

endpackage

>>> sv/sipf_datapath.sv
// rule memory, rule count, scan index, match logic and result registers
module sipf_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sipf_pkg::sipf_cmd_t  cmd,
    output sipf_pkg::sipf_stat_t stat,
    input  logic [1:0]           func,
    input  logic [31:0]          packet_src_addr,
    input  logic [7:0]           packet_protocol,
    input  logic [31:0]          new_rule_src_addr,
    input  logic                 new_rule_forbid,
    input  logic [1:0]           new_rule_class,
    output logic                 drop,
    output logic                 table_full
);
    import sipf_pkg::*;

    rule_t              rule_mem [RULE_SLOTS];
    logic [CNT_W-1:0]   rule_count_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic               rd_vld_reg;
    rule_t              rd_data_reg;
    logic               hit_reg;
    logic               refused_reg;
    logic [1:0]         func_reg;
    logic [31:0]        pkt_src_reg;
    logic [7:0]         pkt_proto_reg;
    rule_t              new_rule_reg;
    logic               drop_reg;
    logic               table_full_reg;
    logic               full;
    logic               do_write;

    assign full     = (rule_count_reg == CNT_W'(RULE_SLOTS));
    assign do_write = cmd.exec && (func_reg == FUNC_ADD) && !full;

    assign stat.need_scan = (func_reg == FUNC_CHECK) && (rule_count_reg != '0);
    assign stat.scan_last = (scan_idx_reg == CNT_W'(rule_count_reg - CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_step;
            if (cmd.exec && func_reg == FUNC_CLEAR)
            begin
                rule_count_reg <= '0;
            end
            else if (do_write)
            begin
                rule_count_reg <= CNT_W'(rule_count_reg + CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg            <= func;
            pkt_src_reg         <= packet_src_addr;
            pkt_proto_reg       <= packet_protocol;
            new_rule_reg.src    <= new_rule_src_addr;
            new_rule_reg.forbid <= new_rule_forbid;
            new_rule_reg.cls    <= new_rule_class;
            hit_reg             <= 1'b0;
            refused_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.exec && func_reg == FUNC_ADD && full)
            begin
                refused_reg <= 1'b1;
            end
            // compare one rule a cycle, in the cycle after its read
            if (rd_vld_reg && rule_hits(rd_data_reg, pkt_src_reg, pkt_proto_reg))
            begin
                hit_reg <= 1'b1;
            end
        end

        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= CNT_W'(scan_idx_reg + CNT_W'(1));
        end

        if (cmd.load_out)
        begin
            drop_reg       <= (func_reg == FUNC_CHECK) && hit_reg;
            table_full_reg <= (func_reg == FUNC_ADD) && refused_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            rule_mem[rule_count_reg[IDX_W-1:0]] <= new_rule_reg;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= rule_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    assign drop       = drop_reg;
    assign table_full = table_full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_count_reg <= CNT_W'(RULE_SLOTS))
        else $error("rule count beyond table size");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> scan_idx_reg < rule_count_reg)
        else $error("scan reads past the last stored rule");

    a_no_write_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !do_write)
        else $error("rule written during a scan");

endmodule

>>> sv/sipf_ctrl.sv
// sequencer for capture, execute, rule scan and result handoff
module sipf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sipf_pkg::sipf_cmd_t  cmd,
    input  sipf_pkg::sipf_stat_t stat
);
    import sipf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read beat is compared here
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before handoff");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

>>> sv/source_ip_protocol_filter_table.sv
// top level of the source address and protocol filter rule table
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+-------------------
//  in      | func, packet_src_addr, packet_protocol,   | in  | in_valid/in_ready
//          | new_rule_src_addr, new_rule_forbid,       |     |
//          | new_rule_class                            |     |
//  out     | drop, table_full                          | out | out_valid/out_ready
//
// one beat in at a time; a check of a non-empty table goes from accept
// through execute, a scan of every stored rule, a drain and the result load,
// set by the single-port rule memory read one entry a cycle
// add, clear, unused codes and a check of an empty table skip the scan
// a waiting result sits in the output register while the next beat is accepted
// reset empties the table at once; stored rules are not cleared
module source_ip_protocol_filter_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] packet_src_addr,
    input  logic [7:0]  packet_protocol,
    input  logic [31:0] new_rule_src_addr,
    input  logic        new_rule_forbid,
    input  logic [1:0]  new_rule_class,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        drop,
    output logic        table_full
);
    import sipf_pkg::*;

    sipf_cmd_t  cmd;
    sipf_stat_t stat;

    sipf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sipf_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .func              (func),
        .packet_src_addr   (packet_src_addr),
        .packet_protocol   (packet_protocol),
        .new_rule_src_addr (new_rule_src_addr),
        .new_rule_forbid   (new_rule_forbid),
        .new_rule_class    (new_rule_class),
        .drop              (drop),
        .table_full        (table_full)
    );

endmodule
